/* hw/rtl/mbp_pkg.sv */
// Shared types and constants for the free-rectangle packer.
package mbp_pkg;

  localparam int MaxFree = 64;
  localparam int IdxW    = $clog2(MaxFree);
  localparam int CntW    = $clog2(MaxFree + 1);
  localparam int SlcDepth = 4 * MaxFree;
  localparam int SlcIdxW = $clog2(SlcDepth);
  localparam int SlcCntW = $clog2(SlcDepth + 1);
  localparam int DimW    = 13;
  localparam int BinMax  = 4096;

  localparam logic [2:0] StPlaced   = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StZeroSize = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StResetDone = 3'd4;

  localparam logic CfgBinWidth  = 1'b0;
  localparam logic CfgBinHeight = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] l;
    logic [DimW-1:0] t;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } rect_t;

  function automatic logic [DimW-1:0] clamp_bin(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(BinMax)) return DimW'(BinMax);
    return v;
  endfunction

  // true when inner lies fully within outer
  function automatic logic rect_inside(input rect_t o, input rect_t n);
    return (n.l >= o.l) && (n.t >= o.t) &&
           ({1'b0, n.l} + {1'b0, n.w} <= {1'b0, o.l} + {1'b0, o.w}) &&
           ({1'b0, n.t} + {1'b0, n.h} <= {1'b0, o.t} + {1'b0, o.h});
  endfunction

endpackage

/* hw/rtl/maxrects_bssf_packer.sv */
// Top level: best-short-side-fit rectangle allocator over a free list.
// A zero-size item goes straight to the result; a reset item first reloads entry zero.
// Insert: scan every entry, test each for overlap and split an overlapping entry into
// slices and remove it, append the slices, then test pruning rows and pairs for removal.
// Flow control: one item at a time, ready only when idle.
// Reset: asynchronous; after release the S_INIT state loads entry zero with the bin.
module maxrects_bssf_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_width[12:0], req_height[25:13], zero pad
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // place_left[11:0], place_top[23:12],
                                      // place_width[36:24], place_height[49:37],
                                      // free_entries[56:50], zero pad
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int DW = mbp_pkg::DimW;
  localparam int CW = mbp_pkg::CntW;
  localparam int IW = mbp_pkg::IdxW;
  localparam int SCW = mbp_pkg::SlcCntW;
  localparam int SIW = mbp_pkg::SlcIdxW;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RSTW    = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_EV = 4'd4;
  localparam logic [3:0] S_SPL_RD  = 4'd5;
  localparam logic [3:0] S_SPL_EV  = 4'd6;
  localparam logic [3:0] S_SPL_SL  = 4'd7;
  localparam logic [3:0] S_DRP_RD  = 4'd8;
  localparam logic [3:0] S_DRP_WR  = 4'd9;
  localparam logic [3:0] S_APP_RD  = 4'd10;
  localparam logic [3:0] S_APP_WR  = 4'd11;
  localparam logic [3:0] S_PR_I    = 4'd12;
  localparam logic [3:0] S_PR_RD   = 4'd13;
  localparam logic [3:0] S_PR_EV   = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  localparam logic [1:0] RET_SPL = 2'd0;
  localparam logic [1:0] RET_PI  = 2'd1;
  localparam logic [1:0] RET_PJ  = 2'd2;

  // memories
  mbp_pkg::rect_t free_mem [mbp_pkg::MaxFree];
  mbp_pkg::rect_t slc_mem  [mbp_pkg::SlcDepth];
  mbp_pkg::rect_t rdata_a_q, rdata_b_q, slc_rdata_q;
  logic [IW-1:0]  raddr_a, raddr_b, waddr;
  logic           we;
  mbp_pkg::rect_t wdata;
  logic [SIW-1:0] slc_raddr, slc_waddr;
  logic           slc_we;
  mbp_pkg::rect_t slc_wdata;

  always_ff @(posedge clk_i) begin
    if (we) free_mem[waddr] <= wdata;
    rdata_a_q <= free_mem[raddr_a];
    rdata_b_q <= free_mem[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (slc_we) slc_mem[slc_waddr] <= slc_wdata;
    slc_rdata_q <= slc_mem[slc_raddr];
  end

  // control and datapath registers
  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  i_q, i_d, j_q, j_d, tgt_q, tgt_d;
  logic [SCW-1:0] k_q, k_d, n_q, n_d;
  logic [1:0]     sub_q, sub_d, ret_q, ret_d;
  logic           best_v_q, best_v_d, lost_q, lost_d;
  logic [DW-1:0]  best_s_q, best_s_d, best_l_q, best_l_d;
  logic [DW-1:0]  pl_q, pl_d, pt_q, pt_d, rw_q, rw_d, rh_q, rh_d;
  mbp_pkg::rect_t f_q, f_d;
  logic [2:0]     st_q, st_d;
  logic [DW-1:0]  bin_w_q, bin_h_q;
  logic           mv_q;
  logic [2:0]     o_st_q;
  logic [11:0]    o_l_q, o_t_q;
  logic [DW-1:0]  o_w_q, o_h_q;
  logic [CW-1:0]  o_n_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = o_st_q;
  assign m_axis_tdata  = {7'd0, o_n_q, o_h_q, o_w_q, o_t_q, o_l_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_w_q <= DW'(512);
      bin_h_q <= DW'(512);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == mbp_pkg::CfgBinWidth) bin_w_q <= cfg_data_i;
      else bin_h_q <= cfg_data_i;
    end
  end

  // fit metrics for the entry being scanned
  logic [DW-1:0] dw, dh, sm, lg;
  logic          fits, better;
  // overlap and slice edges for the entry being split
  logic [DW:0]   pe, pb, fe, fb;
  logic          ovl;

  always_comb begin
    dw     = rdata_a_q.w - rw_q;
    dh     = rdata_a_q.h - rh_q;
    sm     = (dw < dh) ? dw : dh;
    lg     = (dw < dh) ? dh : dw;
    fits   = (rdata_a_q.w >= rw_q) && (rdata_a_q.h >= rh_q);
    better = !best_v_q || (sm < best_s_q) || ((sm == best_s_q) && (lg < best_l_q));
    pe  = {1'b0, pl_q} + {1'b0, rw_q};
    pb  = {1'b0, pt_q} + {1'b0, rh_q};
    fe  = {1'b0, f_q.l} + {1'b0, f_q.w};
    fb  = {1'b0, f_q.t} + {1'b0, f_q.h};
    ovl = ({1'b0, rdata_a_q.l} < {1'b0, pl_q} + {1'b0, rw_q}) &&
          ({1'b0, rdata_a_q.l} + {1'b0, rdata_a_q.w} > {1'b0, pl_q}) &&
          ({1'b0, rdata_a_q.t} < {1'b0, pt_q} + {1'b0, rh_q}) &&
          ({1'b0, rdata_a_q.t} + {1'b0, rdata_a_q.h} > {1'b0, pt_q});
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; tgt_d = tgt_q;
    k_d = k_q; n_d = n_q; sub_d = sub_q; ret_d = ret_q;
    best_v_d = best_v_q; lost_d = lost_q; best_s_d = best_s_q; best_l_d = best_l_q;
    pl_d = pl_q; pt_d = pt_q; rw_d = rw_q; rh_d = rh_q; f_d = f_q; st_d = st_q;
    raddr_a = i_q[IW-1:0]; raddr_b = j_q[IW-1:0];
    we = 1'b0; waddr = '0; wdata = '0;
    slc_we = 1'b0; slc_waddr = n_q[SIW-1:0]; slc_wdata = '0;
    slc_raddr = k_q[SIW-1:0];

    case (state_q)
      S_INIT, S_RSTW: begin
        we = 1'b1;
        wdata = '{l: '0, t: '0, w: mbp_pkg::clamp_bin(bin_w_q),
                  h: mbp_pkg::clamp_bin(bin_h_q)};
        cnt_d = CW'(1);
        state_d = (state_q == S_INIT) ? S_IDLE : S_OUT;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          rw_d = s_axis_tdata[12:0];
          rh_d = s_axis_tdata[25:13];
          pl_d = '0; pt_d = '0;
          if (s_axis_tuser[0]) begin
            st_d = mbp_pkg::StResetDone;
            rw_d = '0; rh_d = '0;
            state_d = S_RSTW;
          end else if (s_axis_tdata[12:0] == '0 || s_axis_tdata[25:13] == '0) begin
            st_d = mbp_pkg::StZeroSize;
            state_d = S_OUT;
          end else begin
            k_d = '0; best_v_d = 1'b0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        raddr_a = k_q[IW-1:0];
        if (k_q < SCW'(cnt_q)) begin
          state_d = S_SCAN_EV;
        end else if (best_v_q) begin
          i_d = '0; n_d = '0; lost_d = 1'b0;
          state_d = S_SPL_RD;
        end else begin
          st_d = mbp_pkg::StNoFit;
          rw_d = '0; rh_d = '0;
          state_d = S_OUT;
        end
      end
      S_SCAN_EV: begin
        if (fits && better) begin
          best_v_d = 1'b1; best_s_d = sm; best_l_d = lg;
          pl_d = rdata_a_q.l; pt_d = rdata_a_q.t;
        end
        k_d = k_q + SCW'(1);
        state_d = S_SCAN_RD;
      end
      S_SPL_RD: begin
        if (i_q < cnt_q) begin
          state_d = S_SPL_EV;
        end else begin
          k_d = '0;
          state_d = S_APP_RD;
        end
      end
      S_SPL_EV: begin
        f_d = rdata_a_q;
        if (ovl) begin
          sub_d = '0;
          state_d = S_SPL_SL;
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_SPL_RD;
        end
      end
      S_SPL_SL: begin
        // emit left, right, top, bottom slices in turn
        case (sub_q)
          2'd0: begin
            slc_we = (pl_q > f_q.l);
            slc_wdata = '{l: f_q.l, t: f_q.t, w: pl_q - f_q.l, h: f_q.h};
          end
          2'd1: begin
            slc_we = (pe < fe);
            slc_wdata = '{l: pe[DW-1:0], t: f_q.t, w: DW'(fe - pe), h: f_q.h};
          end
          2'd2: begin
            slc_we = (pt_q > f_q.t);
            slc_wdata = '{l: f_q.l, t: f_q.t, w: f_q.w, h: pt_q - f_q.t};
          end
          default: begin
            slc_we = (pb < fb);
            slc_wdata = '{l: f_q.l, t: pb[DW-1:0], w: f_q.w, h: DW'(fb - pb)};
          end
        endcase
        if (slc_we) n_d = n_q + SCW'(1);
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          tgt_d = i_q; ret_d = RET_SPL;
          state_d = S_DRP_RD;
        end
      end
      S_DRP_RD: begin
        raddr_b = IW'(cnt_q - CW'(1));
        state_d = S_DRP_WR;
      end
      S_DRP_WR: begin
        // swap last entry into the removed slot
        we = 1'b1; waddr = tgt_q[IW-1:0]; wdata = rdata_b_q;
        cnt_d = cnt_q - CW'(1);
        case (ret_q)
          RET_SPL: state_d = S_SPL_RD;
          RET_PI:  state_d = S_PR_I;
          default: state_d = S_PR_RD;
        endcase
      end
      S_APP_RD: begin
        if (k_q < n_q) begin
          state_d = S_APP_WR;
        end else begin
          i_d = '0;
          state_d = S_PR_I;
        end
      end
      S_APP_WR: begin
        if (cnt_q < CW'(mbp_pkg::MaxFree)) begin
          we = 1'b1; waddr = cnt_q[IW-1:0]; wdata = slc_rdata_q;
          cnt_d = cnt_q + CW'(1);
        end else begin
          lost_d = 1'b1;
        end
        k_d = k_q + SCW'(1);
        state_d = S_APP_RD;
      end
      S_PR_I: begin
        if (i_q < cnt_q) begin
          j_d = i_q + CW'(1);
          state_d = S_PR_RD;
        end else begin
          st_d = lost_q ? mbp_pkg::StOverflow : mbp_pkg::StPlaced;
          state_d = S_OUT;
        end
      end
      S_PR_RD: begin
        if (j_q < cnt_q) begin
          state_d = S_PR_EV;
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_PR_I;
        end
      end
      S_PR_EV: begin
        if (mbp_pkg::rect_inside(rdata_b_q, rdata_a_q)) begin
          tgt_d = i_q; ret_d = RET_PI;
          state_d = S_DRP_RD;
        end else if (mbp_pkg::rect_inside(rdata_a_q, rdata_b_q)) begin
          tgt_d = j_q; ret_d = RET_PJ;
          state_d = S_DRP_RD;
        end else begin
          j_d = j_q + CW'(1);
          state_d = S_PR_RD;
        end
      end
      S_OUT: begin
        if (!mv_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q <= CW'(1);
      mv_q <= 1'b0;
      i_q <= '0; j_q <= '0; tgt_q <= '0; k_q <= '0; n_q <= '0;
      sub_q <= '0; ret_q <= RET_SPL; best_v_q <= 1'b0; lost_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      i_q <= i_d; j_q <= j_d; tgt_q <= tgt_d; k_q <= k_d; n_q <= n_d;
      sub_q <= sub_d; ret_q <= ret_d; best_v_q <= best_v_d; lost_q <= lost_d;
      if (state_q == S_OUT && (!mv_q || m_axis_tready)) mv_q <= 1'b1;
      else if (m_axis_tready) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_s_q <= best_s_d; best_l_q <= best_l_d;
    pl_q <= pl_d; pt_q <= pt_d; rw_q <= rw_d; rh_q <= rh_d;
    f_q <= f_d; st_q <= st_d;
    if (state_q == S_OUT && (!mv_q || m_axis_tready)) begin
      o_st_q <= st_q;
      o_l_q  <= (st_q == mbp_pkg::StPlaced || st_q == mbp_pkg::StOverflow) ?
                pl_q[11:0] : 12'd0;
      o_t_q  <= (st_q == mbp_pkg::StPlaced || st_q == mbp_pkg::StOverflow) ?
                pt_q[11:0] : 12'd0;
      o_w_q  <= rw_q;
      o_h_q  <= rh_q;
      o_n_q  <= cnt_q;
    end
  end

endmodule
